/* rtl/glecc_pkg.sv */
// shared constants, types and register codes of the grid extremum counter
`default_nettype none

package glecc_pkg;

    // defaults for the top level parameters
    localparam int VALUE_WIDTH_DEF = 32;
    localparam int MAX_COLUMNS_DEF = 128;
    localparam int MAX_ROWS_DEF    = 4096;

    // configuration register widths
    localparam int ROW_COUNT_W    = 13;
    localparam int COLUMN_COUNT_W = 8;

    // result field
    localparam int                 TOTAL_W   = 20;
    localparam logic [TOTAL_W-1:0] TOTAL_MAX = {TOTAL_W{1'b1}};

    // apb port
    localparam int CFG_DATA_W = 32;
    localparam int PADDR_W    = 3;

    // queue depths
    localparam int ENTRY_DEPTH = 4;
    localparam int OUT_DEPTH   = 4;

    typedef enum logic {
        REG_ROW_COUNT    = 1'b0,
        REG_COLUMN_COUNT = 1'b1
    } reg_index_t;

    // neighborhood classification of one element, made at the front
    typedef struct packed {
        logic has_up1;    // row above exists
        logic has_up2;    // two rows above exist
        logic has_left1;  // column to the left exists
        logic has_left2;  // two columns to the left exist
        logic has_right;  // column to the right exists
        logic last_row;
        logic last_col;
    } pos_flags_t;

endpackage

`default_nettype wire

/* rtl/glecc_if.sv */
// valid/ready channel interfaces for grid elements and totals
`default_nettype none

interface glecc_cell_if #(
    parameter int VALUE_WIDTH = glecc_pkg::VALUE_WIDTH_DEF
);
    logic                          valid;
    logic                          ready;
    logic signed [VALUE_WIDTH-1:0] cell_value;

    modport source (output valid, output cell_value, input ready);
    modport sink   (input valid, input cell_value, output ready);
endinterface

interface glecc_total_if;
    logic                            valid;
    logic                            ready;
    logic [glecc_pkg::TOTAL_W-1:0]   extremum_total;

    modport source (output valid, output extremum_total, input ready);
    modport sink   (input valid, input extremum_total, output ready);
endinterface

`default_nettype wire

/* rtl/glecc_queue.sv */
// small register fifo with valid/ready on both sides
`default_nettype none

module glecc_queue #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 4
) (
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire logic             push_valid,
    output logic                  push_ready,
    input  wire logic [WIDTH-1:0] push_data,
    output logic                  pop_valid,
    input  wire logic             pop_ready,
    output logic [WIDTH-1:0]      pop_data
);

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    logic [WIDTH-1:0] slot_reg [DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0] count_reg, count_next;
    logic             push;
    logic             pop;

    assign push_ready = (count_reg != CNT_W'(DEPTH));
    assign pop_valid  = (count_reg != '0);
    assign pop_data   = slot_reg[rd_ptr_reg];
    assign push       = push_valid && push_ready;
    assign pop        = pop_valid && pop_ready;

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push)
        begin
            wr_ptr_next = (wr_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_reg + PTR_W'(1);
        end
        if (pop)
        begin
            rd_ptr_next = (rd_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_reg + PTR_W'(1);
        end
        if (push && !pop)
        begin
            count_next = count_reg + CNT_W'(1);
        end
        else if (pop && !push)
        begin
            count_next = count_reg - CNT_W'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            slot_reg[wr_ptr_reg] <= push_data;
        end
    end

endmodule

`default_nettype wire

/* rtl/glecc_front.sv */
// raster position tracking and neighborhood classification of each element
`default_nettype none

module glecc_front #(
    parameter int MAX_COLUMNS = glecc_pkg::MAX_COLUMNS_DEF,
    parameter int MAX_ROWS    = glecc_pkg::MAX_ROWS_DEF,
    parameter int VALUE_WIDTH = glecc_pkg::VALUE_WIDTH_DEF
) (
    input  wire logic                                  clk,
    input  wire logic                                  rst_n,
    input  wire logic                                  restart,
    input  wire logic [glecc_pkg::ROW_COUNT_W-1:0]     row_count,
    input  wire logic [glecc_pkg::COLUMN_COUNT_W-1:0]  column_count,
    input  wire logic                                  in_valid,
    output logic                                       in_ready,
    input  wire logic [VALUE_WIDTH-1:0]                in_value,
    output logic                                       push_valid,
    input  wire logic                                  push_ready,
    output logic [VALUE_WIDTH-1:0]                     entry_value,
    output logic [$clog2(MAX_COLUMNS)-1:0]             entry_col,
    output glecc_pkg::pos_flags_t                      entry_flags
);

    localparam int COL_W = $clog2(MAX_COLUMNS);
    localparam int ROW_W = (MAX_ROWS > 1) ? $clog2(MAX_ROWS) : 1;

    logic [ROW_W-1:0] row_reg, row_next;
    logic [COL_W-1:0] col_reg, col_next;
    logic [ROW_W-1:0] rows_m1;
    logic [COL_W-1:0] cols_m1;
    logic             accept;

    // out-of-range counts: zero acts as one, large values as the maximum
    always_comb
    begin
        if (row_count == '0)
        begin
            rows_m1 = '0;
        end
        else if (int'(row_count) > MAX_ROWS)
        begin
            rows_m1 = ROW_W'(MAX_ROWS - 1);
        end
        else
        begin
            rows_m1 = ROW_W'(row_count - 1'b1);
        end

        if (column_count == '0)
        begin
            cols_m1 = '0;
        end
        else if (int'(column_count) > MAX_COLUMNS)
        begin
            cols_m1 = COL_W'(MAX_COLUMNS - 1);
        end
        else
        begin
            cols_m1 = COL_W'(column_count - 1'b1);
        end
    end

    assign in_ready    = push_ready;
    assign push_valid  = in_valid;
    assign accept      = in_valid && push_ready;
    assign entry_value = in_value;
    assign entry_col   = col_reg;

    always_comb
    begin
        entry_flags.has_up1   = (row_reg != '0);
        entry_flags.has_up2   = (row_reg > ROW_W'(1));
        entry_flags.has_left1 = (col_reg != '0);
        entry_flags.has_left2 = (col_reg > COL_W'(1));
        entry_flags.last_col  = (col_reg == cols_m1);
        entry_flags.has_right = (col_reg != cols_m1);
        entry_flags.last_row  = (row_reg == rows_m1);
    end

    always_comb
    begin
        row_next = row_reg;
        col_next = col_reg;
        if (restart)
        begin
            row_next = '0;
            col_next = '0;
        end
        else if (accept)
        begin
            if (entry_flags.last_col)
            begin
                col_next = '0;
                row_next = entry_flags.last_row ? '0 : row_reg + ROW_W'(1);
            end
            else
            begin
                col_next = col_reg + COL_W'(1);
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            row_reg <= '0;
            col_reg <= '0;
        end
        else
        begin
            row_reg <= row_next;
            col_reg <= col_next;
        end
    end

endmodule

`default_nettype wire

/* rtl/glecc_judge.sv */
// strict extremum test of one element against its present neighbors
`default_nettype none

module glecc_judge #(
    parameter int VALUE_WIDTH = glecc_pkg::VALUE_WIDTH_DEF
) (
    input  wire logic                          enable,
    input  wire logic signed [VALUE_WIDTH-1:0] center,
    input  wire logic signed [VALUE_WIDTH-1:0] up,
    input  wire logic                          has_up,
    input  wire logic signed [VALUE_WIDTH-1:0] down,
    input  wire logic                          has_down,
    input  wire logic signed [VALUE_WIDTH-1:0] left,
    input  wire logic signed [VALUE_WIDTH-1:0] right,
    input  wire logic                          has_left,
    input  wire logic                          has_right,
    output logic                               hit
);

    logic signed [VALUE_WIDTH-1:0] nb [4];
    logic [3:0]                    present;
    logic                          above;
    logic                          below;

    assign nb[0]   = up;
    assign nb[1]   = down;
    assign nb[2]   = left;
    assign nb[3]   = right;
    assign present = {has_right, has_left, has_down, has_up};

    always_comb
    begin
        above = 1'b1;
        below = 1'b1;
        for (int k = 0; k < 4; k++)
        begin
            if (present[k])
            begin
                if (!(center > nb[k]))
                begin
                    above = 1'b0;
                end
                if (!(center < nb[k]))
                begin
                    below = 1'b0;
                end
            end
        end
        hit = enable && (above || below);
    end

endmodule

`default_nettype wire

/* rtl/glecc_back.sv */
// line buffers, neighbor window, extremum decisions and the running total
`default_nettype none

module glecc_back #(
    parameter int MAX_COLUMNS = glecc_pkg::MAX_COLUMNS_DEF,
    parameter int VALUE_WIDTH = glecc_pkg::VALUE_WIDTH_DEF
) (
    input  wire logic                              clk,
    input  wire logic                              rst_n,
    input  wire logic                              restart,
    input  wire logic                              entry_valid,
    output logic                                   entry_ready,
    input  wire logic [VALUE_WIDTH-1:0]            entry_value,
    input  wire logic [$clog2(MAX_COLUMNS)-1:0]    entry_col,
    input  wire glecc_pkg::pos_flags_t             entry_flags,
    output logic                                   out_valid,
    input  wire logic                              out_ready,
    output logic [glecc_pkg::TOTAL_W-1:0]          out_total
);

    localparam int COL_W  = $clog2(MAX_COLUMNS);
    localparam int PEND_W = $clog2(glecc_pkg::OUT_DEPTH + 1);
    localparam int TW     = glecc_pkg::TOTAL_W;

    // row stores: middle holds the latest row, upper the one before it
    logic [VALUE_WIDTH-1:0] middle_mem [MAX_COLUMNS];
    logic [VALUE_WIDTH-1:0] upper_mem  [MAX_COLUMNS];

    logic                   pop;
    logic                   entry_final;
    logic [COL_W-1:0]       mid_n_addr;

    // stage 1: read data and the element in hand
    logic                   s1_valid_reg;
    logic [VALUE_WIDTH-1:0] s1_value_reg;
    logic [COL_W-1:0]       s1_col_reg;
    glecc_pkg::pos_flags_t  s1_flags_reg;
    logic [VALUE_WIDTH-1:0] mid_c_rd_reg;
    logic [VALUE_WIDTH-1:0] mid_n_rd_reg;
    logic [VALUE_WIDTH-1:0] up_c_rd_reg;

    // window history along the row
    logic [VALUE_WIDTH-1:0] prev_mid_reg;
    logic [VALUE_WIDTH-1:0] prev_cell_reg;
    logic [VALUE_WIDTH-1:0] prev2_cell_reg;

    logic                   hit_above;
    logic                   hit_left;
    logic                   hit_self;

    // stage 2: decisions
    logic                   s2_valid_reg;
    logic [2:0]             s2_hits_reg;
    logic                   s2_final_reg;

    logic [TW-1:0]          total_reg, total_next;
    logic [TW:0]            total_sum;
    logic [TW-1:0]          total_sat;
    logic                   out_push;

    logic [PEND_W-1:0]      pending_reg, pending_next;
    logic                   out_taken;

    // a final element may only enter once its result has a queue slot
    assign entry_final = entry_flags.last_row && entry_flags.last_col;
    assign entry_ready = !entry_final || (pending_reg < PEND_W'(glecc_pkg::OUT_DEPTH));
    assign pop         = entry_valid && entry_ready;
    assign mid_n_addr  = entry_flags.has_right ? entry_col + COL_W'(1) : entry_col;

    always_ff @(posedge clk)
    begin
        if (pop)
        begin
            middle_mem[entry_col] <= entry_value;
            mid_c_rd_reg          <= middle_mem[entry_col];
            mid_n_rd_reg          <= middle_mem[mid_n_addr];
        end
    end

    // upper takes the old middle value in the cycle after the middle read; forward it to a read of the same column
    always_ff @(posedge clk)
    begin
        if (s1_valid_reg)
        begin
            upper_mem[s1_col_reg] <= mid_c_rd_reg;
        end
        if (pop)
        begin
            up_c_rd_reg <= (s1_valid_reg && (s1_col_reg == entry_col)) ?
                           mid_c_rd_reg : upper_mem[entry_col];
        end
    end

    always_ff @(posedge clk)
    begin
        if (pop)
        begin
            s1_value_reg <= entry_value;
            s1_col_reg   <= entry_col;
            s1_flags_reg <= entry_flags;
        end
        if (s1_valid_reg)
        begin
            prev_mid_reg   <= mid_c_rd_reg;
            prev_cell_reg  <= s1_value_reg;
            prev2_cell_reg <= prev_cell_reg;
        end
        if (s1_valid_reg)
        begin
            s2_hits_reg  <= {hit_self, hit_left, hit_above};
            s2_final_reg <= s1_flags_reg.last_row && s1_flags_reg.last_col;
        end
    end

    // element in the row above, now that its lower neighbor is here
    glecc_judge #(
        .VALUE_WIDTH (VALUE_WIDTH)
    ) u_judge_above (
        .enable    (s1_flags_reg.has_up1),
        .center    (mid_c_rd_reg),
        .up        (up_c_rd_reg),
        .has_up    (s1_flags_reg.has_up2),
        .down      (s1_value_reg),
        .has_down  (1'b1),
        .left      (prev_mid_reg),
        .right     (mid_n_rd_reg),
        .has_left  (s1_flags_reg.has_left1),
        .has_right (s1_flags_reg.has_right),
        .hit       (hit_above)
    );

    // left neighbor in the last row
    glecc_judge #(
        .VALUE_WIDTH (VALUE_WIDTH)
    ) u_judge_left (
        .enable    (s1_flags_reg.last_row && s1_flags_reg.has_left1),
        .center    (prev_cell_reg),
        .up        (prev_mid_reg),
        .has_up    (s1_flags_reg.has_up1),
        .down      ('0),
        .has_down  (1'b0),
        .left      (prev2_cell_reg),
        .right     (s1_value_reg),
        .has_left  (s1_flags_reg.has_left2),
        .has_right (1'b1),
        .hit       (hit_left)
    );

    // the final element itself
    glecc_judge #(
        .VALUE_WIDTH (VALUE_WIDTH)
    ) u_judge_self (
        .enable    (s1_flags_reg.last_row && s1_flags_reg.last_col),
        .center    (s1_value_reg),
        .up        (mid_c_rd_reg),
        .has_up    (s1_flags_reg.has_up1),
        .down      ('0),
        .has_down  (1'b0),
        .left      (prev_cell_reg),
        .right     ('0),
        .has_left  (s1_flags_reg.has_left1),
        .has_right (1'b0),
        .hit       (hit_self)
    );

    // saturating accumulate
    always_comb
    begin
        total_sum = {1'b0, total_reg} + (TW + 1)'($countones(s2_hits_reg));
        total_sat = (total_sum > {1'b0, glecc_pkg::TOTAL_MAX}) ? glecc_pkg::TOTAL_MAX
                                                              : total_sum[TW-1:0];
        total_next = total_reg;
        if (restart)
        begin
            total_next = '0;
        end
        else if (s2_valid_reg)
        begin
            total_next = s2_final_reg ? '0 : total_sat;
        end
    end

    assign out_push  = s2_valid_reg && s2_final_reg;
    assign out_taken = out_valid && out_ready;

    always_comb
    begin
        pending_next = pending_reg;
        if (pop && entry_final && !out_taken)
        begin
            pending_next = pending_reg + PEND_W'(1);
        end
        else if (out_taken && !(pop && entry_final))
        begin
            pending_next = pending_reg - PEND_W'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
            s2_valid_reg <= 1'b0;
            total_reg    <= '0;
            pending_reg  <= '0;
        end
        else
        begin
            s1_valid_reg <= pop;
            s2_valid_reg <= s1_valid_reg;
            total_reg    <= total_next;
            pending_reg  <= pending_next;
        end
    end

    glecc_queue #(
        .WIDTH (TW),
        .DEPTH (glecc_pkg::OUT_DEPTH)
    ) u_out_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push_valid (out_push),
        .push_ready (),
        .push_data  (total_sat),
        .pop_valid  (out_valid),
        .pop_ready  (out_ready),
        .pop_data   (out_total)
    );

endmodule

`default_nettype wire

/* rtl/grid_local_extrema_counter_core.sv */
// top level of the 4-neighbor grid local extremum counter
`default_nettype none

// Counts the strict local maxima and minima of a signed grid that arrives in
// raster order, one element per transfer on cell_in. An element counts when it is
// strictly above, or strictly below, every neighbor it has among up, down, left
// and right; a 1x1 grid counts its single element. Rows and columns are set
// through the apb registers (row_count at 0x0, column_count at 0x4); a write to
// either restarts the grid, zero acts as one and a value beyond MAX_ROWS or
// MAX_COLUMNS acts as that maximum while the written bits read back unchanged.
// The total goes out as one transfer on total_out once the final element of a grid
// has passed the entry queue, stage 1, stage 2 and the result queue, and saturates
// at 2^20-1. The block takes one element every clock cycle unless total_out stalls:
// a four-entry queue separates the position tracker from the line buffer pipeline,
// which issues one element per cycle into two single-port-write row memories of
// MAX_COLUMNS words (middle read at two columns, upper at one). Only a stalled
// total_out slows the input: up to four totals may wait, after which a further
// final element is held in the queue. The row memories need no clearing pass; no
// element is ever judged against an entry the current grid has not written.

module grid_local_extrema_counter_core #(
    parameter int MAX_COLUMNS = glecc_pkg::MAX_COLUMNS_DEF,
    parameter int MAX_ROWS    = glecc_pkg::MAX_ROWS_DEF,
    parameter int VALUE_WIDTH = glecc_pkg::VALUE_WIDTH_DEF
) (
    input  wire logic                               clk,
    input  wire logic                               rst_n,

    // apb configuration port
    input  wire logic                               psel,
    input  wire logic                               penable,
    input  wire logic                               pwrite,
    input  wire logic [glecc_pkg::PADDR_W-1:0]      paddr,
    input  wire logic [glecc_pkg::CFG_DATA_W-1:0]   pwdata,
    output logic [glecc_pkg::CFG_DATA_W-1:0]        prdata,
    output logic                                    pready,

    // grid elements in, totals out
    glecc_cell_if.sink                              cell_in,
    glecc_total_if.source                           total_out
);

    localparam int COL_W   = $clog2(MAX_COLUMNS);
    localparam int FLAGS_W = $bits(glecc_pkg::pos_flags_t);
    localparam int ENTRY_W = VALUE_WIDTH + COL_W + FLAGS_W;

    logic [glecc_pkg::ROW_COUNT_W-1:0]    row_count_reg, row_count_next;
    logic [glecc_pkg::COLUMN_COUNT_W-1:0] column_count_reg, column_count_next;
    glecc_pkg::reg_index_t                cfg_index;
    logic                                 cfg_write;
    logic                                 restart;

    // front to queue
    logic                                 push_valid;
    logic                                 push_ready;
    logic [VALUE_WIDTH-1:0]               front_value;
    logic [COL_W-1:0]                     front_col;
    glecc_pkg::pos_flags_t                front_flags;

    // queue to back
    logic                                 entry_valid;
    logic                                 entry_ready;
    logic [ENTRY_W-1:0]                   entry_data;
    logic [VALUE_WIDTH-1:0]               entry_value;
    logic [COL_W-1:0]                     entry_col;
    glecc_pkg::pos_flags_t                entry_flags;

    // register file: the high address bit picks the register
    assign pready    = 1'b1;
    assign cfg_index = glecc_pkg::reg_index_t'(paddr[glecc_pkg::PADDR_W-1]);
    assign cfg_write = psel && penable && pwrite && pready;
    assign restart   = cfg_write;

    always_comb
    begin
        row_count_next    = row_count_reg;
        column_count_next = column_count_reg;
        prdata            = '0;
        case (cfg_index)
            glecc_pkg::REG_ROW_COUNT:
            begin
                prdata = glecc_pkg::CFG_DATA_W'(row_count_reg);
                if (cfg_write)
                begin
                    row_count_next = pwdata[glecc_pkg::ROW_COUNT_W-1:0];
                end
            end
            glecc_pkg::REG_COLUMN_COUNT:
            begin
                prdata = glecc_pkg::CFG_DATA_W'(column_count_reg);
                if (cfg_write)
                begin
                    column_count_next = pwdata[glecc_pkg::COLUMN_COUNT_W-1:0];
                end
            end
            default:
            begin
                prdata = '0;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            row_count_reg    <= glecc_pkg::ROW_COUNT_W'(1);
            column_count_reg <= glecc_pkg::COLUMN_COUNT_W'(1);
        end
        else
        begin
            row_count_reg    <= row_count_next;
            column_count_reg <= column_count_next;
        end
    end

    // front: raster position and neighbor flags of each element
    glecc_front #(
        .MAX_COLUMNS (MAX_COLUMNS),
        .MAX_ROWS    (MAX_ROWS),
        .VALUE_WIDTH (VALUE_WIDTH)
    ) u_front (
        .clk          (clk),
        .rst_n        (rst_n),
        .restart      (restart),
        .row_count    (row_count_reg),
        .column_count (column_count_reg),
        .in_valid     (cell_in.valid),
        .in_ready     (cell_in.ready),
        .in_value     (cell_in.cell_value),
        .push_valid   (push_valid),
        .push_ready   (push_ready),
        .entry_value  (front_value),
        .entry_col    (front_col),
        .entry_flags  (front_flags)
    );

    // classified elements wait here so either side can stall alone
    glecc_queue #(
        .WIDTH (ENTRY_W),
        .DEPTH (glecc_pkg::ENTRY_DEPTH)
    ) u_entry_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push_valid (push_valid),
        .push_ready (push_ready),
        .push_data  ({front_value, front_col, front_flags}),
        .pop_valid  (entry_valid),
        .pop_ready  (entry_ready),
        .pop_data   (entry_data)
    );

    assign entry_value = entry_data[ENTRY_W-1 -: VALUE_WIDTH];
    assign entry_col   = entry_data[FLAGS_W +: COL_W];
    assign entry_flags = glecc_pkg::pos_flags_t'(entry_data[FLAGS_W-1:0]);

    // back: line buffers, decisions, total and result queue
    glecc_back #(
        .MAX_COLUMNS (MAX_COLUMNS),
        .VALUE_WIDTH (VALUE_WIDTH)
    ) u_back (
        .clk         (clk),
        .rst_n       (rst_n),
        .restart     (restart),
        .entry_valid (entry_valid),
        .entry_ready (entry_ready),
        .entry_value (entry_value),
        .entry_col   (entry_col),
        .entry_flags (entry_flags),
        .out_valid   (total_out.valid),
        .out_ready   (total_out.ready),
        .out_total   (total_out.extremum_total)
    );

endmodule

`default_nettype wire

/* rtl/glecc_checker.sv */
// port-level checks of the grid extremum counter, bound to the top level
`default_nettype none

module glecc_checker (
    input  wire logic                               clk,
    input  wire logic                               rst_n,
    input  wire logic                               in_valid,
    input  wire logic                               in_ready,
    input  wire logic                               out_valid,
    input  wire logic                               out_ready,
    input  wire logic [glecc_pkg::TOTAL_W-1:0]      out_total,
    input  wire logic                               psel,
    input  wire logic                               penable,
    input  wire logic                               pwrite,
    input  wire logic [glecc_pkg::PADDR_W-1:0]      paddr,
    input  wire logic [glecc_pkg::CFG_DATA_W-1:0]   pwdata,
    input  wire logic [glecc_pkg::CFG_DATA_W-1:0]   prdata
);

    localparam int HI = glecc_pkg::PADDR_W - 1;
    localparam int RW = glecc_pkg::ROW_COUNT_W;
    localparam int CW = glecc_pkg::COLUMN_COUNT_W;

    // a waiting total holds
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(out_total))
        else $error("total changed while stalled");

    // input space is only used up by transfers
    a_in_ready_kept: assert property (@(posedge clk) disable iff (!rst_n)
        in_ready && !in_valid |=> in_ready)
        else $error("input ready dropped with no transfer");

    a_row_readback: assert property (@(posedge clk) disable iff (!rst_n)
        psel && penable && pwrite && !paddr[HI]
        |=> !(psel && !pwrite && !paddr[HI]) || (prdata[RW-1:0] == $past(pwdata[RW-1:0])))
        else $error("row count readback mismatch");

    a_col_readback: assert property (@(posedge clk) disable iff (!rst_n)
        psel && penable && pwrite && paddr[HI]
        |=> !(psel && !pwrite && paddr[HI]) || (prdata[CW-1:0] == $past(pwdata[CW-1:0])))
        else $error("column count readback mismatch");

endmodule

bind grid_local_extrema_counter_core glecc_checker u_glecc_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (cell_in.valid),
    .in_ready  (cell_in.ready),
    .out_valid (total_out.valid),
    .out_ready (total_out.ready),
    .out_total (total_out.extremum_total),
    .psel      (psel),
    .penable   (penable),
    .pwrite    (pwrite),
    .paddr     (paddr),
    .pwdata    (pwdata),
    .prdata    (prdata)
);

`default_nettype wire

/* dv/tb_grid_local_extrema_counter_core.sv */
// self-checking testbench of the grid local extremum counter core
`timescale 1ns / 100ps

module tb_grid_local_extrema_counter_core;

    localparam int CLK_PERIOD   = 10;
    localparam int RESET_CYCLES = 12;
    localparam int MAX_COLUMNS  = glecc_pkg::MAX_COLUMNS_DEF;
    localparam int MAX_ROWS     = glecc_pkg::MAX_ROWS_DEF;
    localparam int VALUE_WIDTH  = glecc_pkg::VALUE_WIDTH_DEF;

    // pause before a register write, covers the entry queue plus the pipeline
    localparam int SETTLE_CYCLES = 16;
    // cycles without any transfer before the run is declared hung
    localparam int STALL_LIMIT   = 4000;
    // random cells per idling phase
    localparam int PHASE_ITEMS   = 340;

    localparam logic signed [VALUE_WIDTH-1:0] CELL_MIN = {1'b1, {(VALUE_WIDTH-1){1'b0}}};
    localparam logic signed [VALUE_WIDTH-1:0] CELL_MAX = {1'b0, {(VALUE_WIDTH-1){1'b1}}};

    // how the values of a random grid are drawn
    typedef enum int {
        FILL_WIDE,
        FILL_NARROW,
        FILL_EDGES,
        FILL_MIXED
    } fill_style_t;

    logic clk   = 1'b0;
    logic rst_n = 1'b0;

    // apb configuration port
    logic                                psel    = 1'b0;
    logic                                penable = 1'b0;
    logic                                pwrite  = 1'b0;
    logic [glecc_pkg::PADDR_W-1:0]       paddr   = '0;
    logic [glecc_pkg::CFG_DATA_W-1:0]    pwdata  = '0;
    logic [glecc_pkg::CFG_DATA_W-1:0]    prdata;
    logic                                pready;

    glecc_cell_if #(.VALUE_WIDTH(VALUE_WIDTH)) cell_if ();
    glecc_total_if                             total_if ();

    grid_local_extrema_counter_core #(
        .MAX_COLUMNS (MAX_COLUMNS),
        .MAX_ROWS    (MAX_ROWS),
        .VALUE_WIDTH (VALUE_WIDTH)
    ) dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .psel      (psel),
        .penable   (penable),
        .pwrite    (pwrite),
        .paddr     (paddr),
        .pwdata    (pwdata),
        .prdata    (prdata),
        .pready    (pready),
        .cell_in   (cell_if),
        .total_out (total_if)
    );

    always #(CLK_PERIOD / 2) clk = ~clk;

    // cells still to be offered, and totals the counter model says will come out
    logic signed [VALUE_WIDTH-1:0]    cell_backlog[$];
    logic [glecc_pkg::TOTAL_W-1:0]    expected_totals[$];

    int unsigned send_idle_pct = 34;
    int unsigned recv_idle_pct = 88;
    int unsigned mismatch_count = 0;
    int unsigned stall_cycles = 0;
    bit          cell_moved = 1'b0;
    logic [glecc_pkg::TOTAL_W-1:0] total_want;

    // ------------------------------------------------------------------
    // counter model: own copy of the line buffers, raster position and
    // configuration, advanced once per accepted cell
    // ------------------------------------------------------------------
    logic signed [VALUE_WIDTH-1:0]           upper_row [MAX_COLUMNS];
    logic signed [VALUE_WIDTH-1:0]           middle_row[MAX_COLUMNS];
    logic signed [VALUE_WIDTH-1:0]           last_cell = '0;
    logic [glecc_pkg::ROW_COUNT_W-1:0]       row_reg = 1;
    logic [glecc_pkg::COLUMN_COUNT_W-1:0]    col_reg = 1;
    logic [glecc_pkg::TOTAL_W-1:0]           found_total = '0;
    int unsigned                             row_pos = 0;
    int unsigned                             col_pos = 0;

    function automatic int unsigned rows_in_effect();
        if (row_reg == 0)
            return 1;
        if (row_reg > MAX_ROWS)
            return MAX_ROWS;
        return row_reg;
    endfunction

    function automatic int unsigned cols_in_effect();
        if (col_reg == 0)
            return 1;
        if (col_reg > MAX_COLUMNS)
            return MAX_COLUMNS;
        return col_reg;
    endfunction

    function automatic void restart_count();
        row_pos     = 0;
        col_pos     = 0;
        found_total = '0;
    endfunction

    // center counts when strictly above all present neighbors or strictly below all
    function automatic void judge_cell(input logic signed [VALUE_WIDTH-1:0] center,
                                       input logic [3:0][VALUE_WIDTH-1:0] around,
                                       input logic [3:0] present);
        bit above;
        bit below;
        above = 1'b1;
        below = 1'b1;
        for (int k = 0; k < 4; k++)
        begin
            if (present[k])
            begin
                if (!(center > $signed(around[k])))
                    above = 1'b0;
                if (!(center < $signed(around[k])))
                    below = 1'b0;
            end
        end
        if ((above || below) && found_total != glecc_pkg::TOTAL_MAX)
            found_total = found_total + 1'b1;
    endfunction

    function automatic void count_extrema_step(input logic signed [VALUE_WIDTH-1:0] cur);
        int unsigned rows;
        int unsigned cols;
        int unsigned r;
        int unsigned c;
        bit          last_row;
        bit          last_col;
        rows = rows_in_effect();
        cols = cols_in_effect();
        r    = (row_pos >= rows) ? rows - 1 : row_pos;
        c    = (col_pos >= cols) ? cols - 1 : col_pos;
        last_row = (r == rows - 1);
        last_col = (c == cols - 1);

        // the cell above now has its lower neighbor
        if (r >= 1)
            judge_cell(middle_row[c],
                       {upper_row[c], cur,
                        (c >= 1) ? upper_row[c-1] : {VALUE_WIDTH{1'b0}},
                        (c + 1 < cols) ? middle_row[c+1] : {VALUE_WIDTH{1'b0}}},
                       {r >= 2, 1'b1, c >= 1, c + 1 < cols});

        upper_row[c]  = middle_row[c];
        middle_row[c] = cur;

        if (last_row)
        begin
            // in the bottom row the left cell is complete once its right arrives
            if (c >= 1)
                judge_cell(last_cell,
                           {upper_row[c-1], {VALUE_WIDTH{1'b0}},
                            (c >= 2) ? middle_row[c-2] : {VALUE_WIDTH{1'b0}}, cur},
                           {r >= 1, 1'b0, c >= 2, 1'b1});
            if (last_col)
                judge_cell(cur,
                           {upper_row[c], {VALUE_WIDTH{1'b0}}, last_cell,
                            {VALUE_WIDTH{1'b0}}},
                           {r >= 1, 1'b0, c >= 1, 1'b0});
        end

        last_cell = cur;

        if (last_row && last_col)
        begin
            expected_totals.push_back(found_total);
            restart_count();
        end
        else if (last_col)
        begin
            col_pos = 0;
            row_pos = r + 1;
        end
        else
        begin
            col_pos = c + 1;
            row_pos = r;
        end
    endfunction

    function automatic void apply_register(input glecc_pkg::reg_index_t idx,
                                           input logic [glecc_pkg::CFG_DATA_W-1:0] value);
        if (idx == glecc_pkg::REG_ROW_COUNT)
            row_reg = value[glecc_pkg::ROW_COUNT_W-1:0];
        else
            col_reg = value[glecc_pkg::COLUMN_COUNT_W-1:0];
        restart_count();
    endfunction

    // ------------------------------------------------------------------
    // stimulus helpers
    // ------------------------------------------------------------------
    function automatic logic signed [VALUE_WIDTH-1:0] random_cell(input fill_style_t style);
        fill_style_t pick;
        pick = style;
        if (style == FILL_MIXED)
            pick = fill_style_t'($urandom_range(0, 2));
        case (pick)
            // tiny range, so ties and plateaus are common
            FILL_NARROW: return int'($urandom_range(0, 4)) - 2;
            FILL_EDGES:
            begin
                case ($urandom_range(0, 4))
                    0:       return CELL_MIN;
                    1:       return CELL_MAX;
                    2:       return 0;
                    3:       return -1;
                    default: return 1;
                endcase
            end
            default:     return $urandom();
        endcase
    endfunction

    function automatic void queue_random_grid(input int unsigned cells,
                                              input fill_style_t style);
        for (int unsigned k = 0; k < cells; k++)
            cell_backlog.push_back(random_cell(style));
    endfunction

    // block is idle: nothing left to offer, every total in, pipeline drained
    task automatic settle();
        while (cell_backlog.size() != 0 || expected_totals.size() != 0)
            @(negedge clk);
        repeat (SETTLE_CYCLES) @(negedge clk);
    endtask

    // apb write followed by a readback of the same register
    task automatic program_register(input glecc_pkg::reg_index_t idx,
                                    input logic [glecc_pkg::CFG_DATA_W-1:0] value);
        logic [glecc_pkg::CFG_DATA_W-1:0] kept;
        logic [glecc_pkg::CFG_DATA_W-1:0] readback;
        if (idx == glecc_pkg::REG_ROW_COUNT)
            kept = value & ((32'd1 << glecc_pkg::ROW_COUNT_W) - 1);
        else
            kept = value & ((32'd1 << glecc_pkg::COLUMN_COUNT_W) - 1);

        @(negedge clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 2'b00};
        pwdata  <= value;
        @(negedge clk);
        penable <= 1'b1;
        do @(posedge clk); while (!pready);
        apply_register(idx, value);

        // straight into the setup phase of the readback
        @(negedge clk);
        penable <= 1'b0;
        pwrite  <= 1'b0;
        @(negedge clk);
        penable <= 1'b1;
        do @(posedge clk); while (!pready);
        readback = prdata;
        if (readback != kept)
        begin
            $error("%s: expected %0d, got %0d", idx.name(), kept, readback);
            mismatch_count++;
        end
        @(negedge clk);
        psel    <= 1'b0;
        penable <= 1'b0;
    endtask

    // new grid shape, registers written in random order
    task automatic resize_grid(input logic [glecc_pkg::CFG_DATA_W-1:0] row_raw,
                               input logic [glecc_pkg::CFG_DATA_W-1:0] col_raw);
        settle();
        if ($urandom_range(0, 1))
        begin
            program_register(glecc_pkg::REG_ROW_COUNT, row_raw);
            program_register(glecc_pkg::REG_COLUMN_COUNT, col_raw);
        end
        else
        begin
            program_register(glecc_pkg::REG_COLUMN_COUNT, col_raw);
            program_register(glecc_pkg::REG_ROW_COUNT, row_raw);
        end
    endtask

    // ------------------------------------------------------------------
    // cell driver: a transfer happens at the rising edge, the next cell or
    // an idle gap is put up at the falling edge
    // ------------------------------------------------------------------
    always @(posedge clk)
    begin
        if (rst_n && cell_if.valid && cell_if.ready)
        begin
            count_extrema_step(cell_if.cell_value);
            void'(cell_backlog.pop_front());
            cell_moved = 1'b1;
        end
    end

    always @(negedge clk)
    begin
        if (!rst_n)
            cell_if.valid <= 1'b0;
        else if (!cell_if.valid || cell_moved)
        begin
            // a held cell stays up until its transfer
            if (cell_backlog.size() != 0 && $urandom_range(0, 99) >= send_idle_pct)
            begin
                cell_if.valid      <= 1'b1;
                cell_if.cell_value <= cell_backlog[0];
            end
            else
                cell_if.valid <= 1'b0;
        end
        cell_moved = 1'b0;
    end

    // ------------------------------------------------------------------
    // total monitor with random back-pressure
    // ------------------------------------------------------------------
    always @(negedge clk)
        total_if.ready <= ($urandom_range(0, 99) >= recv_idle_pct);

    always @(posedge clk)
    begin
        if (rst_n && total_if.valid && total_if.ready)
        begin
            if (expected_totals.size() == 0)
            begin
                $error("extremum_total: expected none, got %0d", total_if.extremum_total);
                mismatch_count++;
            end
            else
            begin
                total_want = expected_totals.pop_front();
                if (total_if.extremum_total !== total_want)
                begin
                    $error("extremum_total: expected %0d, got %0d",
                           total_want, total_if.extremum_total);
                    mismatch_count++;
                end
            end
        end
    end

    // ------------------------------------------------------------------
    // watchdog: counts cycles with no transfer on either channel
    // ------------------------------------------------------------------
    always @(posedge clk)
    begin
        if (!rst_n)
            stall_cycles <= 0;
        else if ((cell_if.valid && cell_if.ready) || (total_if.valid && total_if.ready))
            stall_cycles <= 0;
        else
            stall_cycles <= stall_cycles + 1;
    end

    initial
    begin
        wait (stall_cycles >= STALL_LIMIT);
        $display("** grid_local_extrema_counter_core: FAILED **");
        $finish;
    end

    // ------------------------------------------------------------------
    // test sequence
    // ------------------------------------------------------------------
    initial
    begin
        int unsigned rows_eff;
        int unsigned cols_eff;
        int unsigned grid_cells;
        int unsigned repeats;
        int unsigned phase_items;
        logic [glecc_pkg::CFG_DATA_W-1:0] row_raw;
        logic [glecc_pkg::CFG_DATA_W-1:0] col_raw;

        cell_if.valid      = 1'b0;
        cell_if.cell_value = '0;
        total_if.ready     = 1'b0;
        for (int k = 0; k < MAX_COLUMNS; k++)
        begin
            upper_row[k]  = '0;
            middle_row[k] = '0;
        end

        repeat (RESET_CYCLES) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        // reset shape is 1x1: each cell is a whole grid and counts
        cell_backlog.push_back(CELL_MIN);
        cell_backlog.push_back(CELL_MAX);

        // zero in both registers still means 1x1
        resize_grid(0, 0);
        cell_backlog.push_back(-1);

        // 3x3 with a single peak; the border cells all tie
        resize_grid(3, 3);
        for (int k = 0; k < 9; k++)
            cell_backlog.push_back((k == 4) ? CELL_MAX : 0);

        // 2x3 checkerboard of the extreme values, every cell counts
        resize_grid(2, 3);
        for (int k = 0; k < 6; k++)
            cell_backlog.push_back(((k / 3 + k % 3) % 2) ? CELL_MAX : CELL_MIN);

        // single row with a tie at the start
        resize_grid(1, 3);
        cell_backlog.push_back(5);
        cell_backlog.push_back(5);
        cell_backlog.push_back(7);

        // abandoned grid: the next write restarts counting
        resize_grid(2, 2);
        cell_backlog.push_back(9);
        cell_backlog.push_back(-9);
        resize_grid(2, 1);
        cell_backlog.push_back(1);
        cell_backlog.push_back(2);

        // random grids over the three idling phases
        for (int phase = 0; phase < 3; phase++)
        begin
            settle();
            case (phase)
                0:
                begin
                    send_idle_pct = 34;
                    recv_idle_pct = 88;
                end
                1:
                begin
                    send_idle_pct = 88;
                    recv_idle_pct = 34;
                end
                default:
                begin
                    send_idle_pct = 0;
                    recv_idle_pct = 0;
                end
            endcase

            phase_items = 0;
            while (phase_items < PHASE_ITEMS)
            begin
                case ($urandom_range(0, 9))
                    0:
                    begin
                        // wide grid up to the line buffer size
                        rows_eff = $urandom_range(1, 3);
                        cols_eff = $urandom_range(0, 1) ? MAX_COLUMNS
                                                        : $urandom_range(100, MAX_COLUMNS - 1);
                    end
                    1:
                    begin
                        // tall and narrow
                        rows_eff = $urandom_range(20, 48);
                        cols_eff = $urandom_range(1, 3);
                    end
                    2:
                    begin
                        rows_eff = 1;
                        cols_eff = 1;
                    end
                    default:
                    begin
                        rows_eff = $urandom_range(1, 8);
                        cols_eff = $urandom_range(1, 12);
                    end
                endcase

                // out of range register values that map onto the same shape
                row_raw = (rows_eff == 1 && $urandom_range(0, 1)) ? 0 : rows_eff;
                if (cols_eff == 1 && $urandom_range(0, 1))
                    col_raw = 0;
                else if (cols_eff == MAX_COLUMNS && $urandom_range(0, 1))
                    col_raw = $urandom_range(MAX_COLUMNS + 1,
                                             (1 << glecc_pkg::COLUMN_COUNT_W) - 1);
                else
                    col_raw = cols_eff;
                resize_grid(row_raw, col_raw);

                // back-to-back grids of one shape, now and then cut short
                repeats = $urandom_range(1, 3);
                for (int unsigned k = 0; k < repeats; k++)
                begin
                    grid_cells = rows_eff * cols_eff;
                    if ($urandom_range(0, 9) == 0)
                    begin
                        grid_cells = $urandom_range(0, grid_cells - 1);
                        k = repeats;
                    end
                    // the phase budget cuts the last grid short
                    if (grid_cells >= PHASE_ITEMS - phase_items)
                    begin
                        grid_cells = PHASE_ITEMS - phase_items;
                        k = repeats;
                    end
                    queue_random_grid(grid_cells, fill_style_t'($urandom_range(0, 3)));
                    phase_items += grid_cells;
                end
            end
        end

        // row count far above the maximum, abandoned by the next write
        resize_grid((1 << glecc_pkg::ROW_COUNT_W) - 1, 0);
        queue_random_grid(40, FILL_NARROW);
        // column count above the line buffer size, run without idling
        resize_grid(2, (1 << glecc_pkg::COLUMN_COUNT_W) - 1);
        queue_random_grid(2 * MAX_COLUMNS, FILL_EDGES);

        settle();
        if (mismatch_count == 0)
            $display("** grid_local_extrema_counter_core: PASSED **");
        else
            $display("** grid_local_extrema_counter_core: FAILED **");
        $finish;
    end

endmodule
